@@ rtl/core/dpcs_pkg.sv @@
package dpcs_pkg;

  // Field widths of the word formats.
  localparam int KIND_W   = 3;
  localparam int FRAME_W  = 8;
  localparam int COUNT_W  = 9;
  localparam int ACTION_W = 2;
  localparam int STATUS_W = 2;
  localparam int INFL_W   = 10;
  localparam int FILL_W   = 10;

  typedef logic [KIND_W-1:0]   kind_t;
  typedef logic [FRAME_W-1:0]  frame_t;
  typedef logic [COUNT_W-1:0]  count_t;
  typedef logic [ACTION_W-1:0] action_t;
  typedef logic [STATUS_W-1:0] status_t;
  typedef logic [INFL_W-1:0]   infl_t;
  typedef logic [FILL_W-1:0]   fill_t;

  typedef struct packed {
    kind_t  kind;
    frame_t frame;
    count_t dirty_count;
  } in_word_t;

  typedef struct packed {
    action_t action;
    frame_t  sched_frame;
    status_t status;
    infl_t   inflight;
    fill_t   queue_fill;
  } out_word_t;

  // Input word kinds.
  localparam kind_t KIND_RESET       = kind_t'(0);
  localparam kind_t KIND_ENQUEUE     = kind_t'(1);
  localparam kind_t KIND_FLUSH_SCHED = kind_t'(2);
  localparam kind_t KIND_FLUSH_DONE  = kind_t'(3);
  localparam kind_t KIND_EVALUATE    = kind_t'(4);

  // Result actions.
  localparam action_t ACT_NONE  = action_t'(0);
  localparam action_t ACT_SEED  = action_t'(1);
  localparam action_t ACT_SCHED = action_t'(2);

  // Result status codes.
  localparam status_t STS_OK    = status_t'(0);
  localparam status_t STS_RANGE = status_t'(1);
  localparam status_t STS_DUP   = status_t'(2);
  localparam status_t STS_FULL  = status_t'(3);

  // Register indexes on the configuration port.
  localparam logic [1:0] REG_ENABLE = 2'd0;
  localparam logic [1:0] REG_FRAMES = 2'd1;
  localparam logic [1:0] REG_HIGH   = 2'd2;
  localparam logic [1:0] REG_LOW    = 2'd3;

  // Register reset values.
  localparam count_t FRAMES_RST = count_t'(256);
  localparam count_t HIGH_RST   = count_t'(192);
  localparam count_t LOW_RST    = count_t'(128);

  localparam infl_t INFLIGHT_MAX = '1;

endpackage

@@ rtl/core/dpcs_ram.sv @@
module dpcs_ram #(
  parameter int Width = 8,
  parameter int Depth = 4
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Synchronous write and registered read; a read of the entry being
  // written in the same cycle returns the old contents.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/core/dirty_page_cleaner_scheduler.sv @@
// Dirty page cleaner scheduler.
// Input words arrive on in_valid_i/in_ready_o/in_word_i and each one yields
// exactly one result word on out_valid_o/out_ready_i/out_word_o. Kinds are:
// reset candidate, enqueue candidate, flush scheduled, flush finished and
// evaluate. Per-frame state (enqueued flag and generation) lives in one
// single-port-write RAM, the candidate queue of frame/generation pairs in a
// second one; both have a registered read.
// Flush scheduled/finished and unknown kinds finish at once; reset and
// enqueue read and then write the frame state. Evaluate finishes at once
// when it does nothing or requests seeding from an empty queue; otherwise
// it pops queue entries, stale ones included, until one is live or the
// queue is empty, and each pop reads the queue RAM and then the frame RAM.
// The block works on one word at a time but accepts the next input word
// while a finished result still waits in the output register; it then holds
// the new result until the receiver takes the old one.
// After reset the frame RAM is cleared one entry per cycle, all POOL_FRAMES
// entries, and in_ready_o stays low until that pass ends. The APB port
// takes register writes at any time; pready is always high.
module dirty_page_cleaner_scheduler #(
  parameter int POOL_FRAMES = 256,
  parameter int QUEUE_DEPTH = 512,
  parameter int GEN_BITS    = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  dpcs_pkg::in_word_t   in_word_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output dpcs_pkg::out_word_t  out_word_o,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [3:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  localparam int FaW = $clog2(POOL_FRAMES);
  localparam int QaW = $clog2(QUEUE_DEPTH);
  localparam int QcW = $clog2(QUEUE_DEPTH + 1);
  localparam int FmW = GEN_BITS + 1;
  localparam int CqW = dpcs_pkg::FRAME_W + GEN_BITS;

  typedef logic [FaW-1:0]      faddr_t;
  typedef logic [QaW-1:0]      qaddr_t;
  typedef logic [QcW-1:0]      qcount_t;
  typedef logic [GEN_BITS-1:0] gen_t;

  // Sequencer states.
  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_FRD   = 3'd2;
  localparam logic [2:0] S_HRD   = 3'd3;
  localparam logic [2:0] S_HCHK  = 3'd4;
  localparam logic [2:0] S_RESP  = 3'd5;

  // Configuration registers.
  logic              en_q;
  dpcs_pkg::count_t  frames_q, high_q, low_q;
  logic              cfg_we;

  // Control state.
  logic [2:0]        state_q, state_d;
  faddr_t            clr_q, clr_d;
  qaddr_t            head_q, head_d, tail_q, tail_d;
  qcount_t           cnt_q, cnt_d;
  dpcs_pkg::infl_t   infl_q, infl_d;
  logic              out_valid_q, out_valid_d;

  // Payload registers.
  dpcs_pkg::kind_t   kind_q, kind_d;
  dpcs_pkg::frame_t  frame_q, frame_d;
  dpcs_pkg::frame_t  cand_frame_q, cand_frame_d;
  gen_t              cand_gen_q, cand_gen_d;
  dpcs_pkg::out_word_t res_q, res_d, out_word_q, out_word_d;

  // Memory ports.
  logic              fm_we, fm_re;
  faddr_t            fm_waddr, fm_raddr;
  logic [FmW-1:0]    fm_wdata, fm_rdata;
  logic              fm_flag;
  gen_t              fm_gen;
  logic              cq_we, cq_re;
  qaddr_t            cq_waddr, cq_raddr;
  logic [CqW-1:0]    cq_wdata, cq_rdata;
  dpcs_pkg::frame_t  cq_frame;

  // Evaluate decision and finishing controls.
  dpcs_pkg::count_t  budget;
  logic              eval_go;
  logic              fin;
  dpcs_pkg::action_t fin_action;
  dpcs_pkg::frame_t  fin_sched;
  dpcs_pkg::status_t fin_status;
  logic              out_free;

  function automatic logic frame_ok(input dpcs_pkg::frame_t f);
    return ({1'b0, f} < frames_q) && (32'(f) < POOL_FRAMES);
  endfunction

  function automatic qaddr_t q_next(input qaddr_t p);
    return (p == qaddr_t'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  dpcs_ram #(
    .Width(FmW),
    .Depth(POOL_FRAMES)
  ) u_frame_ram (
    .clk_i  (clk_i),
    .we_i   (fm_we),
    .waddr_i(fm_waddr),
    .wdata_i(fm_wdata),
    .re_i   (fm_re),
    .raddr_i(fm_raddr),
    .rdata_o(fm_rdata)
  );

  dpcs_ram #(
    .Width(CqW),
    .Depth(QUEUE_DEPTH)
  ) u_cand_ram (
    .clk_i  (clk_i),
    .we_i   (cq_we),
    .waddr_i(cq_waddr),
    .wdata_i(cq_wdata),
    .re_i   (cq_re),
    .raddr_i(cq_raddr),
    .rdata_o(cq_rdata)
  );

  assign fm_flag  = fm_rdata[FmW-1];
  assign fm_gen   = fm_rdata[GEN_BITS-1:0];
  assign cq_frame = cq_rdata[CqW-1 -: dpcs_pkg::FRAME_W];

  // Configuration port. Writes land at the access phase; reads are plain
  // muxes of the registers.
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_comb begin
    prdata = '0;
    unique case (paddr[3:2])
      dpcs_pkg::REG_ENABLE: prdata = {31'b0, en_q};
      dpcs_pkg::REG_FRAMES: prdata = {23'b0, frames_q};
      dpcs_pkg::REG_HIGH:   prdata = {23'b0, high_q};
      dpcs_pkg::REG_LOW:    prdata = {23'b0, low_q};
      default:              prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q     <= 1'b0;
      frames_q <= dpcs_pkg::FRAMES_RST;
      high_q   <= dpcs_pkg::HIGH_RST;
      low_q    <= dpcs_pkg::LOW_RST;
    end else if (cfg_we) begin
      unique case (paddr[3:2])
        dpcs_pkg::REG_ENABLE: en_q     <= pwdata[0];
        dpcs_pkg::REG_FRAMES: frames_q <= pwdata[8:0];
        dpcs_pkg::REG_HIGH:   high_q   <= pwdata[8:0];
        dpcs_pkg::REG_LOW:    low_q    <= pwdata[8:0];
        default: ;
      endcase
    end
  end

  // An evaluate word only acts when the cleaner is running, the dirty count
  // has reached the high watermark and fewer flushes are in flight than the
  // distance down to the low watermark.
  assign budget  = (in_word_i.dirty_count > low_q) ? in_word_i.dirty_count - low_q : '0;
  assign eval_go = en_q && (in_word_i.dirty_count >= high_q) && (budget != '0) &&
                   (infl_q < {1'b0, budget});

  assign in_ready_o = (state_q == S_IDLE);
  assign out_free   = !out_valid_q || out_ready_i;

  always_comb begin
    state_d      = state_q;
    clr_d        = clr_q;
    head_d       = head_q;
    tail_d       = tail_q;
    cnt_d        = cnt_q;
    infl_d       = infl_q;
    kind_d       = kind_q;
    frame_d      = frame_q;
    cand_frame_d = cand_frame_q;
    cand_gen_d   = cand_gen_q;
    res_d        = res_q;
    out_word_d   = out_word_q;
    out_valid_d  = out_ready_i ? 1'b0 : out_valid_q;
    fm_we        = 1'b0;
    fm_waddr     = '0;
    fm_wdata     = '0;
    fm_re        = 1'b0;
    fm_raddr     = '0;
    cq_we        = 1'b0;
    cq_waddr     = tail_q;
    cq_wdata     = '0;
    cq_re        = 1'b0;
    cq_raddr     = head_q;
    fin          = 1'b0;
    fin_action   = dpcs_pkg::ACT_NONE;
    fin_sched    = '0;
    fin_status   = dpcs_pkg::STS_OK;

    unique case (state_q)
      S_CLEAR: begin
        fm_we    = 1'b1;
        fm_waddr = clr_q;
        if (clr_q == faddr_t'(POOL_FRAMES - 1)) begin
          state_d = S_IDLE;
        end else begin
          clr_d = clr_q + 1'b1;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          kind_d  = in_word_i.kind;
          frame_d = in_word_i.frame;
          if (in_word_i.kind == dpcs_pkg::KIND_RESET ||
              in_word_i.kind == dpcs_pkg::KIND_ENQUEUE) begin
            fm_re    = 1'b1;
            fm_raddr = faddr_t'(in_word_i.frame);
            state_d  = S_FRD;
          end else if (in_word_i.kind == dpcs_pkg::KIND_FLUSH_SCHED) begin
            if (infl_q != dpcs_pkg::INFLIGHT_MAX) begin
              infl_d = infl_q + 1'b1;
            end
            fin = 1'b1;
          end else if (in_word_i.kind == dpcs_pkg::KIND_FLUSH_DONE) begin
            if (infl_q != '0) begin
              infl_d = infl_q - 1'b1;
            end
            fin = 1'b1;
          end else if (in_word_i.kind == dpcs_pkg::KIND_EVALUATE && eval_go) begin
            if (cnt_q == '0) begin
              fin        = 1'b1;
              fin_action = dpcs_pkg::ACT_SEED;
            end else begin
              cq_re   = 1'b1;
              state_d = S_HRD;
            end
          end else begin
            fin = 1'b1;
          end
        end
      end
      S_FRD: begin
        // Frame state read data is valid here.
        fin      = 1'b1;
        fm_waddr = faddr_t'(frame_q);
        if (!frame_ok(frame_q)) begin
          fin_status = dpcs_pkg::STS_RANGE;
        end else if (kind_q == dpcs_pkg::KIND_RESET) begin
          // Bumping the generation makes older queue entries stale.
          fm_we    = 1'b1;
          fm_wdata = {1'b0, fm_gen + 1'b1};
        end else if (fm_flag) begin
          fin_status = dpcs_pkg::STS_DUP;
        end else if (cnt_q == qcount_t'(QUEUE_DEPTH)) begin
          fin_status = dpcs_pkg::STS_FULL;
        end else begin
          fm_we    = 1'b1;
          fm_wdata = {1'b1, fm_gen};
          cq_we    = 1'b1;
          cq_wdata = {frame_q, fm_gen};
          tail_d   = q_next(tail_q);
          cnt_d    = cnt_q + 1'b1;
        end
      end
      S_HRD: begin
        // Pop the head entry and look up the state of its frame.
        cand_frame_d = cq_frame;
        cand_gen_d   = cq_rdata[GEN_BITS-1:0];
        head_d       = q_next(head_q);
        cnt_d        = cnt_q - 1'b1;
        fm_re        = 1'b1;
        fm_raddr     = faddr_t'(cq_frame);
        state_d      = S_HCHK;
      end
      S_HCHK: begin
        if (frame_ok(cand_frame_q) && fm_flag && (fm_gen == cand_gen_q)) begin
          fm_we      = 1'b1;
          fm_waddr   = faddr_t'(cand_frame_q);
          fm_wdata   = {1'b0, fm_gen};
          fin        = 1'b1;
          fin_action = dpcs_pkg::ACT_SCHED;
          fin_sched  = cand_frame_q;
        end else if (cnt_q == '0) begin
          fin        = 1'b1;
          fin_action = dpcs_pkg::ACT_SEED;
        end else begin
          cq_re   = 1'b1;
          state_d = S_HRD;
        end
      end
      S_RESP: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_word_d  = res_q;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // A finished word goes straight to the output register when it is free,
    // otherwise it waits in the result register.
    if (fin) begin
      res_d.action      = fin_action;
      res_d.sched_frame = fin_sched;
      res_d.status      = fin_status;
      res_d.inflight    = infl_d;
      res_d.queue_fill  = dpcs_pkg::fill_t'(cnt_d);
      if (out_free) begin
        out_valid_d = 1'b1;
        out_word_d  = res_d;
        state_d     = S_IDLE;
      end else begin
        state_d = S_RESP;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      head_q      <= '0;
      tail_q      <= '0;
      cnt_q       <= '0;
      infl_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      cnt_q       <= cnt_d;
      infl_q      <= infl_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q       <= kind_d;
    frame_q      <= frame_d;
    cand_frame_q <= cand_frame_d;
    cand_gen_q   <= cand_gen_d;
    res_q        <= res_d;
    out_word_q   <= out_word_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule

@@ tb/tb_dirty_page_cleaner_scheduler.sv @@
`timescale 1ns / 1ps

module tb_dirty_page_cleaner_scheduler;
  import dpcs_pkg::*;

  // Sizes the block is built with. The predictor keeps its own state at the
  // same sizes.
  localparam int POOL  = 256;
  localparam int DEPTH = 512;
  localparam int GEN_W = 16;

  // Kinds 5 to 7 have no meaning. The block must answer them with an
  // all-quiet result and change nothing.
  localparam kind_t KIND_SPARE5 = kind_t'(5);
  localparam kind_t KIND_SPARE6 = kind_t'(6);
  localparam kind_t KIND_SPARE7 = kind_t'(7);

  // One candidate queue entry: the frame and the generation it had when it
  // was enqueued.
  typedef struct packed {
    frame_t           frame;
    bit [GEN_W-1:0]   gen;
  } cand_t;

  // Every input starts at a known value. Reset is held low from time zero.
  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  in_word_t  in_word_i   = '0;
  logic      out_ready_i = 1'b0;
  logic      psel        = 1'b0;
  logic      penable     = 1'b0;
  logic      pwrite      = 1'b0;
  logic [3:0]  paddr     = '0;
  logic [31:0] pwdata    = '0;
  logic        in_ready_o;
  logic        out_valid_o;
  out_word_t   out_word_o;
  logic [31:0] prdata;
  logic        pready;

  dirty_page_cleaner_scheduler #(
    .POOL_FRAMES(POOL),
    .QUEUE_DEPTH(DEPTH),
    .GEN_BITS   (GEN_W)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_word_i  (in_word_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_word_o (out_word_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  // Words waiting to go out on the input channel, and the result words that
  // the predictor says must come back, oldest first.
  in_word_t  words_to_send[$];
  out_word_t results_due[$];

  // Count of accepted input words. The receiver uses it to place its long
  // hold-off.
  int words_sent = 0;
  int mismatches = 0;

  // Predictor state. The register copies follow the reset values of the
  // block and change only when the APB task writes a register.
  logic   run_en     = 1'b0;
  count_t pool_limit = FRAMES_RST;
  count_t dirty_hi   = HIGH_RST;
  count_t dirty_lo   = LOW_RST;
  bit             frame_listed[POOL];
  bit [GEN_W-1:0] frame_gen[POOL];
  cand_t          candidates[$];
  infl_t          flushes_out = '0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Safety net against a hung handshake.
  initial begin
    #3ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic bit frame_in_pool(input frame_t f);
    return {1'b0, f} < pool_limit;
  endfunction

  // Works out the result of one accepted word and advances the predictor
  // state, exactly as the block must.
  task automatic predict_cleaner_word(input in_word_t w);
    out_word_t r;
    cand_t     c;
    int        budget;
    bit        found;
    r = '0;
    case (w.kind)
      KIND_RESET: begin
        if (!frame_in_pool(w.frame)) begin
          r.status = STS_RANGE;
        end else begin
          // The new generation makes older queue entries of this frame stale.
          frame_listed[w.frame] = 1'b0;
          frame_gen[w.frame]++;
        end
      end
      KIND_ENQUEUE: begin
        if (!frame_in_pool(w.frame)) begin
          r.status = STS_RANGE;
        end else if (frame_listed[w.frame]) begin
          r.status = STS_DUP;
        end else if (candidates.size() >= DEPTH) begin
          // Dropped words leave the flag clear, so a retry is not a duplicate.
          r.status = STS_FULL;
        end else begin
          frame_listed[w.frame] = 1'b1;
          c.frame = w.frame;
          c.gen   = frame_gen[w.frame];
          candidates.push_back(c);
        end
      end
      KIND_FLUSH_SCHED: begin
        if (flushes_out != INFLIGHT_MAX) flushes_out++;
      end
      KIND_FLUSH_DONE: begin
        if (flushes_out != '0) flushes_out--;
      end
      KIND_EVALUATE: begin
        if (run_en && w.dirty_count >= dirty_hi) begin
          budget = (w.dirty_count > dirty_lo) ? int'(w.dirty_count) - int'(dirty_lo) : 0;
          if (budget != 0 && int'(flushes_out) < budget) begin
            // Pop from the head until one entry is still live: in range,
            // flagged, and of the current generation.
            found = 1'b0;
            while (candidates.size() != 0 && !found) begin
              c = candidates[0];
              candidates.delete(0);
              if (frame_in_pool(c.frame) && frame_listed[c.frame] &&
                  frame_gen[c.frame] == c.gen) begin
                frame_listed[c.frame] = 1'b0;
                r.sched_frame = c.frame;
                found = 1'b1;
              end
            end
            r.action = found ? ACT_SCHED : ACT_SEED;
          end
        end
      end
      default: begin
      end
    endcase
    r.inflight   = flushes_out;
    r.queue_fill = fill_t'(candidates.size());
    results_due.push_back(r);
  endtask

  task automatic note_mismatch(input string what, input logic [63:0] want,
                               input logic [63:0] got);
    if (mismatches < 10) begin
      $display("ERROR at %0t: %s expected %0h, got %0h", $realtime, what, want, got);
    end
    mismatches++;
  endtask

  // Sender. It works in bursts of random length with random gaps between
  // them; some bursts come with no gap at all. Each accepted word is passed
  // to the predictor at the edge that accepts it. Valid and the word each
  // get a single assignment per edge, so a valid that stays high for the
  // next word never drops in between.
  always @(posedge clk_i) begin : sender
    in_word_t nxt_word;
    logic     nxt_valid;
    logic     fire;
    int       gap_left;
    int       burst_left;
    fire      = in_valid_i && (in_ready_o === 1'b1);
    nxt_valid = in_valid_i;
    nxt_word  = in_word_i;
    if (fire) begin
      predict_cleaner_word(in_word_i);
      words_sent <= words_sent + 1;
    end
    if (!in_valid_i || fire) begin
      nxt_valid = 1'b0;
      if (gap_left != 0) begin
        gap_left--;
      end else if (words_to_send.size() != 0) begin
        nxt_word  = words_to_send[0];
        words_to_send.delete(0);
        nxt_valid = 1'b1;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 48);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end
      end
    end
    in_valid_i <= nxt_valid;
    in_word_i  <= nxt_word;
  end

  // Receiver. Its ready follows a pattern of its own: stretches that are
  // always ready, stretches of light and of heavy stalling. Once, after 400
  // accepted words, it holds off while the sender keeps offering, so the
  // block fills its output register and must stall its input.
  always @(posedge clk_i) begin : receiver
    int hold_left;
    int mode_left;
    int rdy_mode;
    bit hold_done;
    if (hold_left != 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else if (!hold_done && words_sent >= 400) begin
      hold_done = 1'b1;
      hold_left = 300;
      out_ready_i <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        rdy_mode  = $urandom_range(0, 3);
        mode_left = $urandom_range(10, 80);
      end
      mode_left--;
      case (rdy_mode)
        0:       out_ready_i <= 1'b1;
        1:       out_ready_i <= 1'($urandom_range(0, 1));
        2:       out_ready_i <= ($urandom_range(0, 3) == 0);
        default: out_ready_i <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  // Result checker. Every accepted result word is matched, field by field,
  // against the oldest prediction.
  always @(posedge clk_i) begin : result_check
    out_word_t want;
    if (out_valid_o === 1'b1 && out_ready_i) begin
      if (results_due.size() == 0) begin
        note_mismatch("result word with none predicted", '0, 64'(out_word_o));
      end else begin
        want = results_due[0];
        results_due.delete(0);
        if (out_word_o.action !== want.action)
          note_mismatch("action", 64'(want.action), 64'(out_word_o.action));
        if (out_word_o.sched_frame !== want.sched_frame)
          note_mismatch("sched_frame", 64'(want.sched_frame),
                        64'(out_word_o.sched_frame));
        if (out_word_o.status !== want.status)
          note_mismatch("status", 64'(want.status), 64'(out_word_o.status));
        if (out_word_o.inflight !== want.inflight)
          note_mismatch("inflight", 64'(want.inflight), 64'(out_word_o.inflight));
        if (out_word_o.queue_fill !== want.queue_fill)
          note_mismatch("queue_fill", 64'(want.queue_fill),
                        64'(out_word_o.queue_fill));
      end
    end
  end

  // One APB write: setup cycle, then access cycle. The register takes the
  // value at the edge that ends the access cycle, which is also when the
  // predictor's copy changes.
  task automatic apb_write(input logic [1:0] idx, input logic [31:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_ENABLE: run_en     = value[0];
      REG_FRAMES: pool_limit = count_t'(value);
      REG_HIGH:   dirty_hi   = count_t'(value);
      REG_LOW:    dirty_lo   = count_t'(value);
      default: begin
      end
    endcase
  endtask

  task automatic set_registers(input logic en, input int frames, input int hi,
                               input int lo);
    apb_write(REG_ENABLE, 32'(en));
    apb_write(REG_FRAMES, 32'(frames));
    apb_write(REG_HIGH, 32'(hi));
    apb_write(REG_LOW, 32'(lo));
    @(negedge clk_i);
  endtask

  // Every word yields exactly one result, so once the last predicted result
  // is taken the block has nothing left in progress. Spare cycles then
  // follow before any register changes.
  task automatic wait_idle();
    @(negedge clk_i);
    while (words_to_send.size() != 0 || in_valid_i || results_due.size() != 0)
      @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic queue_word(input kind_t k, input int f, input int d);
    in_word_t w;
    w.kind        = k;
    w.frame       = frame_t'(f);
    w.dirty_count = count_t'(d);
    words_to_send.push_back(w);
  endtask

  // A random word. eval_pct sets the share of evaluations; frames are mostly
  // drawn from 0..frame_hi, and now and then from the whole field. Dirty
  // counts are mostly in the pool range, sometimes anywhere in the field.
  function automatic in_word_t random_word(input int eval_pct, input int frame_hi);
    in_word_t    w;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < eval_pct) begin
      w.kind = KIND_EVALUATE;
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 20)      w.kind = KIND_RESET;
      else if (pick < 60) w.kind = KIND_ENQUEUE;
      else if (pick < 75) w.kind = KIND_FLUSH_SCHED;
      else if (pick < 95) w.kind = KIND_FLUSH_DONE;
      else                w.kind = kind_t'($urandom_range(5, 7));
    end
    w.frame = ($urandom_range(0, 3) == 0) ? frame_t'($urandom)
                                          : frame_t'($urandom_range(0, frame_hi));
    w.dirty_count = ($urandom_range(0, 9) == 0) ? count_t'($urandom)
                                                : count_t'($urandom_range(0, 256));
    return w;
  endfunction

  initial begin : stimulus
    int order[POOL];
    int k;
    int j;
    int tmp;
    int f;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part. The pool is cut to 200 frames so the range checks bite,
    // and the watermarks are low so budgets stay small and easy to reach.
    set_registers(1'b1, 200, 10, 5);
    queue_word(KIND_ENQUEUE, 0, 0);
    queue_word(KIND_ENQUEUE, 0, 0);         // duplicate
    queue_word(KIND_ENQUEUE, 255, 511);     // frame beyond the pool
    queue_word(KIND_RESET, 255, 0);
    queue_word(KIND_RESET, 200, 0);         // first frame past the pool
    queue_word(KIND_ENQUEUE, 199, 0);       // last frame in the pool
    queue_word(KIND_RESET, 0, 0);           // head entry goes stale by flag
    queue_word(KIND_FLUSH_DONE, 0, 0);      // in-flight count must not wrap below 0
    queue_word(KIND_FLUSH_SCHED, 0, 0);
    queue_word(KIND_FLUSH_SCHED, 0, 0);
    queue_word(KIND_EVALUATE, 0, 9);        // below the high watermark
    queue_word(KIND_EVALUATE, 0, 256);      // skips the stale head, flushes 199
    queue_word(KIND_EVALUATE, 0, 256);      // empty queue asks for seeding
    queue_word(KIND_SPARE5, 255, 511);
    queue_word(KIND_SPARE6, 0, 0);
    queue_word(KIND_SPARE7, 170, 256);
    repeat (3) queue_word(KIND_FLUSH_SCHED, 0, 0);
    queue_word(KIND_EVALUATE, 0, 10);       // budget equals in-flight: no action
    queue_word(KIND_ENQUEUE, 7, 0);
    queue_word(KIND_RESET, 7, 0);
    queue_word(KIND_ENQUEUE, 7, 0);         // older entry now stale by generation
    queue_word(KIND_EVALUATE, 0, 11);
    queue_word(KIND_EVALUATE, 0, 11);
    wait_idle();

    // General traffic at the reset watermarks.
    set_registers(1'b1, FRAMES_RST, HIGH_RST, LOW_RST);
    repeat (150) words_to_send.push_back(random_word(30, 255));
    wait_idle();

    // Fill the queue while the cleaner is shut down: every frame once in a
    // random order, then reset and re-enqueue pairs that each add one entry
    // until the queue overflows. Evaluations in between must do nothing.
    set_registers(1'b0, 256, 0, 0);
    for (k = 0; k < POOL; k++) order[k] = k;
    for (k = POOL - 1; k > 0; k--) begin
      j        = $urandom_range(0, k);
      tmp      = order[k];
      order[k] = order[j];
      order[j] = tmp;
    end
    for (k = 0; k < POOL; k++) queue_word(KIND_ENQUEUE, order[k], $urandom_range(0, 511));
    f = 0;
    for (k = 0; k < 270; k++) begin
      f = $urandom_range(0, 255);
      queue_word(KIND_RESET, f, $urandom_range(0, 511));
      queue_word(KIND_ENQUEUE, f, $urandom_range(0, 511));
      if ($urandom_range(0, 15) == 0) words_to_send.push_back(random_word(50, 255));
    end
    queue_word(KIND_ENQUEUE, f, 0);         // retry after a drop is not a duplicate
    wait_idle();

    // Drain with the pool shrunk to 128 frames, so entries of the upper
    // frames are thrown away as out of range; the budget equals the dirty
    // count here.
    set_registers(1'b1, 128, 0, 0);
    repeat (160) words_to_send.push_back(random_word(65, 255));
    wait_idle();

    // Smallest pool: only frame 0 is valid, and only dirty counts above 256
    // give any budget.
    set_registers(1'b1, 1, 100, 256);
    repeat (100) words_to_send.push_back(random_word(30, 1));
    wait_idle();

    // Top watermarks: evaluation stays quiet unless the dirty count lies
    // above 256, and the in-flight count moves both ways.
    set_registers(1'b1, 256, 256, 256);
    repeat (6) queue_word(KIND_FLUSH_SCHED, $urandom_range(0, 255), $urandom_range(0, 511));
    queue_word(KIND_EVALUATE, 0, 511);
    queue_word(KIND_EVALUATE, 0, 256);
    repeat (3) queue_word(KIND_FLUSH_DONE, $urandom_range(0, 255), 0);
    repeat (100) words_to_send.push_back(random_word(30, 255));
    wait_idle();

    repeat (20) @(negedge clk_i);
    if (results_due.size() != 0)
      note_mismatch("results still outstanding", '0, 64'(results_due.size()));
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
